### rtl/go_back_n_sender_window_unit_defines.svh
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit_defines
// Assertion macros used by the checker file of the sender window unit.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, codes and constants shared by the sender window unit modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Event codes on the input channel
    localparam logic [1:0] FUNC_MSG = 2'd0;
    localparam logic [1:0] FUNC_ACK = 2'd1;
    localparam logic [1:0] FUNC_TMO = 2'd2;

    // Register indexes (address bit 2)
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_FRAME = 1'b1;

    // Register reset values
    localparam logic [7:0] FIRST_RESET = 8'd127;
    localparam logic [7:0] FRAME_RESET = 8'd128;

    // Frame count divider: 17-bit dividend, one quotient bit per step
    localparam int DIV_W   = 17;
    localparam int DCNT_W  = 5;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_REJECT = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIVIDE,
        S_MSG_EVAL,
        S_REJECT,
        S_START,
        S_FILL,
        S_STOP,
        S_TSTART,
        S_RESEND
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    commit;
        logic    set_timer;
        logic    clr_timer;
        logic    slide;
        logic    fill_step;
        logic    idx_clr;
        logic    idx_inc;
        logic    emit;
        logic    seq_idx;
        t_action action;
        logic    last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_msg;
        logic is_ack;
        logic is_tmo;
        logic ack_ok;
        logic overflow;
        logic queue_empty;
        logic in_window;
        logic fill_more;
        logic fill_last;
        logic inflight_zero;
        logic idx_last;
        logic timer_on;
        logic out_free;
    } t_status;

endpackage

### rtl/gbn_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_regs
// APB-style register file holding the two payload size registers.
// ----------------------------------------------------------------------------
module gbn_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_first_payload,
    output logic [7:0]  o_frame_payload
);
    import gbn_pkg::*;

    logic [7:0] r_first;
    logic [7:0] r_frame;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_RESET;
            r_frame <= FRAME_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_FIRST: r_first <= pwdata[7:0];
                REG_FRAME: r_frame <= pwdata[7:0];
                default:   r_first <= r_first;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            REG_FIRST: prdata = {24'd0, r_first};
            REG_FRAME: prdata = {24'd0, r_frame};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_first_payload = r_first;
    assign o_frame_payload = r_frame;

endmodule

### rtl/gbn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state, frame count divider, event capture and result register.
// ----------------------------------------------------------------------------
module gbn_datapath #(
    parameter int WINDOW_FRAMES = 8,
    parameter int QUEUE_FRAMES  = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbn_pkg::t_cmd   i_cmd,
    output gbn_pkg::t_status o_sts,
    input  logic [1:0]      i_func,
    input  logic [15:0]     i_msg_len,
    input  logic [31:0]     i_ack_seq,
    input  logic            i_ack_ok,
    input  logic [7:0]      i_first_payload,
    input  logic [7:0]      i_frame_payload,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_action,
    output logic [31:0]     o_frame_seq,
    output logic            o_last
);
    import gbn_pkg::*;

    localparam int IW = $clog2(WINDOW_FRAMES + 1);
    localparam logic [IW-1:0] WIN   = IW'(WINDOW_FRAMES);
    localparam logic [32:0]   QLIM  = 33'(QUEUE_FRAMES);

    // Window state
    logic [31:0]   r_next;
    logic [31:0]   r_base;
    logic [IW-1:0] r_inflight;
    logic          r_timer;
    logic [IW-1:0] r_idx;

    // Captured event
    logic [1:0]    r_func;
    logic [31:0]   r_ack;
    logic          r_ok;

    // Divider
    logic [7:0]       r_lp;
    logic [7:0]       r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DCNT_W-1:0] r_dcnt;

    // Result register
    logic          r_out_valid;
    t_action       r_action;
    logic [31:0]   r_seq;
    logic          r_last;

    logic [7:0]       fp_eff;
    logic [7:0]       lp_eff;
    logic [DIV_W-1:0] dividend;
    logic [8:0]       trial;
    logic             qbit;
    logic [DIV_W-1:0] count;
    logic [31:0]      queued;
    logic [31:0]      ack_off;
    logic [IW-1:0]    inflight_inc;
    logic [IW-1:0]    idx_inc;
    logic [31:0]      seq_sel;

    // Zero payload setting counts as one
    assign fp_eff = (i_first_payload == 8'd0) ? 8'd1 : i_first_payload;
    assign lp_eff = (i_frame_payload == 8'd0) ? 8'd1 : i_frame_payload;

    // Ceiling dividend for the frames after the first
    assign dividend = ({8'd0, i_msg_len} > {16'd0, fp_eff}) ?
        (DIV_W'(i_msg_len) - DIV_W'(fp_eff) + DIV_W'(lp_eff) - DIV_W'(1)) :
        '0;

    // One restoring division step
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign qbit  = (trial >= {1'b0, r_lp});

    assign count        = r_quo + DIV_W'(1);
    assign queued       = r_next - r_base;
    assign ack_off      = r_ack - r_base;
    assign inflight_inc = r_inflight + IW'(1);
    assign idx_inc      = r_idx + IW'(1);
    assign seq_sel      = r_base + (i_cmd.seq_idx ? 32'(r_idx) : 32'(r_inflight));

    // Capture the event and load the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_ack  <= i_ack_seq;
            r_ok   <= i_ack_ok;
            r_lp   <= lp_eff;
            r_rem  <= 8'd0;
            r_quo  <= dividend;
        end else if (i_cmd.div_step) begin
            r_rem  <= qbit ? 8'(trial - {1'b0, r_lp}) : trial[7:0];
            r_quo  <= {r_quo[DIV_W-2:0], qbit};
        end
    end

    // Step counter of the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.load) begin
            r_dcnt <= DCNT_W'(DIV_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // Sequence numbers and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next     <= 32'd0;
            r_base     <= 32'd0;
            r_inflight <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_next <= r_next + 32'(count);
            end
            if (i_cmd.slide) begin
                r_base     <= r_base + ack_off + 32'd1;
                r_inflight <= r_inflight - ack_off[IW-1:0] - IW'(1);
            end else if (i_cmd.fill_step) begin
                r_inflight <= inflight_inc;
            end
        end
    end

    // Timer flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= 1'b0;
        end else if (i_cmd.set_timer) begin
            r_timer <= 1'b1;
        end else if (i_cmd.clr_timer) begin
            r_timer <= 1'b0;
        end
    end

    // Resend index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_inc;
        end
    end

    // Result register: load on emit, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_action <= i_cmd.action;
            r_seq    <= (i_cmd.action == ACT_SEND) ? seq_sel : 32'd0;
            r_last   <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_frame_seq = r_seq;
    assign o_last      = r_last;

    // Status to the controller
    always_comb begin
        o_sts.div_done      = (r_dcnt == '0);
        o_sts.is_msg        = (r_func == FUNC_MSG);
        o_sts.is_ack        = (r_func == FUNC_ACK);
        o_sts.is_tmo        = (r_func == FUNC_TMO);
        o_sts.ack_ok        = r_ok;
        o_sts.overflow      = (33'(queued) + 33'(count)) > QLIM;
        o_sts.queue_empty   = (r_next == r_base);
        o_sts.in_window     = (ack_off < 32'(r_inflight));
        o_sts.fill_more     = (r_inflight < WIN) && (32'(r_inflight) < queued);
        o_sts.fill_last     = !((inflight_inc < WIN) && (32'(inflight_inc) < queued));
        o_sts.inflight_zero = (r_inflight == '0);
        o_sts.idx_last      = (idx_inc == r_inflight);
        o_sts.timer_on      = r_timer;
        o_sts.out_free      = !r_out_valid || i_out_ready;
    end

endmodule

### rtl/gbn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ctrl
// Event sequencer: dispatches each event and steps out its results.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output gbn_pkg::t_cmd    o_cmd,
    input  gbn_pkg::t_status i_sts
);
    import gbn_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.is_msg) begin
                    n_state = S_DIVIDE;
                end else if (i_sts.is_ack) begin
                    if (i_sts.queue_empty)                       n_state = S_STOP;
                    else if (i_sts.ack_ok && i_sts.in_window)    n_state = S_START;
                    else                                         n_state = S_IDLE;
                end else if (i_sts.is_tmo) begin
                    n_state = i_sts.inflight_zero ? S_IDLE : S_TSTART;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVIDE: begin
                if (i_sts.div_done) n_state = S_MSG_EVAL;
            end
            S_MSG_EVAL: begin
                if (i_sts.overflow)      n_state = S_REJECT;
                else if (i_sts.timer_on) n_state = S_IDLE;
                else                     n_state = S_START;
            end
            S_REJECT, S_STOP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_START: begin
                if (i_sts.out_free) begin
                    if (i_sts.fill_more)          n_state = S_FILL;
                    else if (i_sts.inflight_zero) n_state = S_STOP;
                    else                          n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (i_sts.out_free && i_sts.fill_last) n_state = S_IDLE;
            end
            S_TSTART: begin
                if (i_sts.out_free) n_state = S_RESEND;
            end
            S_RESEND: begin
                if (i_sts.out_free && i_sts.idx_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.action = ACT_SEND;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH: begin
                if (i_sts.is_ack && !i_sts.queue_empty && i_sts.ack_ok && i_sts.in_window) begin
                    o_cmd.slide = 1'b1;
                end
                if (i_sts.is_tmo && i_sts.inflight_zero) begin
                    o_cmd.clr_timer = 1'b1;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = !i_sts.div_done;
            end
            S_MSG_EVAL: begin
                o_cmd.commit = !i_sts.overflow;
            end
            S_REJECT: begin
                o_cmd.emit   = i_sts.out_free;
                o_cmd.action = ACT_REJECT;
                o_cmd.last   = 1'b1;
            end
            S_START: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.set_timer = i_sts.out_free;
                o_cmd.action    = ACT_START;
                o_cmd.last      = !i_sts.fill_more && !i_sts.inflight_zero;
            end
            S_FILL: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.fill_step = i_sts.out_free;
                o_cmd.action    = ACT_SEND;
                o_cmd.last      = i_sts.fill_last;
            end
            S_STOP: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.clr_timer = i_sts.out_free;
                o_cmd.action    = ACT_STOP;
                o_cmd.last      = 1'b1;
            end
            S_TSTART: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.set_timer = i_sts.out_free;
                o_cmd.idx_clr   = i_sts.out_free;
                o_cmd.action    = ACT_START;
            end
            S_RESEND: begin
                o_cmd.emit    = i_sts.out_free;
                o_cmd.idx_inc = i_sts.out_free;
                o_cmd.seq_idx = 1'b1;
                o_cmd.action  = ACT_SEND;
                o_cmd.last    = i_sts.idx_last;
            end
            default: begin
                o_cmd.action = ACT_SEND;
            end
        endcase
    end

endmodule

### rtl/go_back_n_sender_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N sender window control: frames messages, tracks the window,
// and issues transmit and timer actions for messages, acks and timeouts.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_func, i_msg_len, i_ack_seq, i_ack_ok
// output    out        o_out_valid / i_out_ready o_action, o_frame_seq, o_last
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One event at a time. A new message passes through accept, dispatch,
// 17 divider steps, a done check and evaluate, then issues its results one
// per cycle while the output is free; an ack or a timeout passes through
// accept and dispatch before its results. The frame count divider is
// bit-serial. Reset clears the window state and loads the payload registers
// with 127 and 128. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit #(
    parameter int WINDOW_FRAMES = 8,
    parameter int QUEUE_FRAMES  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_msg_len,
    input  logic [31:0] i_ack_seq,
    input  logic        i_ack_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [31:0] o_frame_seq,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gbn_pkg::*;

    t_cmd       cmd;
    t_status    sts;
    logic [7:0] first_payload;
    logic [7:0] frame_payload;

    // Payload size registers
    gbn_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_first_payload (first_payload),
        .o_frame_payload (frame_payload)
    );

    // Event sequencer
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Window state and result register
    gbn_datapath #(
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .QUEUE_FRAMES  (QUEUE_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_msg_len       (i_msg_len),
        .i_ack_seq       (i_ack_seq),
        .i_ack_ok        (i_ack_ok),
        .i_first_payload (first_payload),
        .i_frame_payload (frame_payload),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_frame_seq     (o_frame_seq),
        .o_last          (o_last)
    );

endmodule

### rtl/gbn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the sender window unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_unit_defines.svh"

module gbn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_action,
    input logic [31:0] o_frame_seq,
    input logic        o_last
);
    import gbn_pkg::*;

    // Stalled result holds
    `GBN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_action) && $stable(o_frame_seq) && $stable(o_last), "stalled result changed")

    // One event at a time: no accept right after an accept
    `GBN_ASSERT_NEXT(a_one_event, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transfer")

    // Only transmit results carry a sequence number
    `GBN_ASSERT_NOW(a_seq_zero, i_clk, i_rst_n, o_out_valid && (o_action != ACT_SEND), o_frame_seq == 32'd0, "non-transmit result with nonzero sequence")

    // Stop and reject always close an event
    `GBN_ASSERT_NOW(a_stop_last, i_clk, i_rst_n, o_out_valid && ((o_action == ACT_STOP) || (o_action == ACT_REJECT)), o_last, "stop or reject not marked last")

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_action    (o_action),
    .o_frame_seq (o_frame_seq),
    .o_last      (o_last)
);

### test/tb_go_back_n_sender_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window_unit
// Self-checking bench for the Go-Back-N sender window unit. Events go in over
// a valid/ready channel and a scoreboard predicts each transmit, timer and
// reject action. Results are checked field by field, in order. The bench runs
// directed corner events first, then random event streams under several
// payload register settings. Both sides idle in short random bursts, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_window_unit;
    import gbn_pkg::*;

    localparam int WINDOW_FRAMES = 8;
    localparam int QUEUE_FRAMES  = 1024;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_EVENTS  = 57;
    localparam longint CYCLE_LIMIT = 400000;

    // Event code the block leaves unused
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        t_action     act;
        logic [31:0] seq;
        logic        last;
    } t_frame_action;

    // Window predictor and store of pending actions
    class gbn_window_scoreboard;
        logic [7:0]    first_bytes;
        logic [7:0]    frame_bytes;
        logic [31:0]   next_num;
        logic [31:0]   base_seq;
        int unsigned   in_flight;
        bit            timer_on;
        t_frame_action action_q[$];
        int unsigned   fails;

        function new();
            first_bytes = FIRST_RESET;
            frame_bytes = FRAME_RESET;
            next_num    = '0;
            base_seq    = '0;
            in_flight   = 0;
            timer_on    = 1'b0;
            fails       = 0;
        endfunction

        function void set_reg(logic sel, logic [7:0] value);
            if (sel == REG_FIRST) begin
                first_bytes = value;
            end else begin
                frame_bytes = value;
            end
        endfunction

        function int unsigned queued();
            return next_num - base_seq;
        endfunction

        function int unsigned pending();
            return action_q.size();
        endfunction

        function void push(t_action act, logic [31:0] seq);
            t_frame_action rec;
            rec.act  = act;
            rec.seq  = (act == ACT_SEND) ? seq : '0;
            rec.last = 1'b0;
            action_q.insert(action_q.size(), rec);
        endfunction

        // Send queued frames until the window is full or the queue runs dry
        function void fill_window();
            while (in_flight < WINDOW_FRAMES && in_flight < queued()) begin
                push(ACT_SEND, base_seq + in_flight);
                in_flight++;
            end
        endfunction

        function void restart_and_fill();
            timer_on = 1'b1;
            push(ACT_START, '0);
            fill_window();
            if (in_flight == 0) begin
                timer_on = 1'b0;
                push(ACT_STOP, '0);
            end
        endfunction

        // Predict the actions of one accepted event
        function void note_event(logic [1:0] func, logic [15:0] len,
                                 logic [31:0] ack, logic ok);
            int unsigned before_n;
            int unsigned fp;
            int unsigned lp;
            int unsigned frames;
            logic [31:0] offset;
            int unsigned i;

            before_n = action_q.size();

            case (func)
                FUNC_MSG: begin
                    // A zero payload register counts as one byte
                    fp = (first_bytes == 0) ? 1 : first_bytes;
                    lp = (frame_bytes == 0) ? 1 : frame_bytes;
                    frames = 1;
                    if (len > fp) begin
                        frames += (len - fp + lp - 1) / lp;
                    end
                    if (queued() + frames > QUEUE_FRAMES) begin
                        push(ACT_REJECT, '0);
                    end else begin
                        next_num += frames;
                        if (!timer_on) begin
                            restart_and_fill();
                        end
                    end
                end
                FUNC_ACK: begin
                    if (next_num == base_seq) begin
                        timer_on = 1'b0;
                        push(ACT_STOP, '0);
                    end else if (ok) begin
                        offset = ack - base_seq;
                        if (offset < in_flight) begin
                            base_seq  += offset + 1;
                            in_flight -= offset + 1;
                            restart_and_fill();
                        end
                    end
                end
                FUNC_TMO: begin
                    if (in_flight == 0) begin
                        timer_on = 1'b0;
                    end else begin
                        timer_on = 1'b1;
                        push(ACT_START, '0);
                        for (i = 0; i < in_flight; i++) begin
                            push(ACT_SEND, base_seq + i);
                        end
                    end
                end
                default: begin
                end
            endcase

            if (action_q.size() > before_n) begin
                action_q[action_q.size() - 1].last = 1'b1;
            end
        endfunction

        // Compare one transferred result with the oldest pending action
        function void check_result(logic [1:0] act, logic [31:0] seq, logic last);
            t_frame_action want;
            if (action_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected result: action %0d seq %0d last %0b",
                         $time, act, seq, last);
                return;
            end
            want = action_q.pop_front();
            if (act !== want.act) begin
                fails++;
                $display("%0t: action mismatch: expected %0d, actual %0d",
                         $time, want.act, act);
            end
            if (seq !== want.seq) begin
                fails++;
                $display("%0t: frame_seq mismatch: expected %0d, actual %0d",
                         $time, want.seq, seq);
            end
            if (last !== want.last) begin
                fails++;
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [15:0] i_msg_len;
    logic [31:0] i_ack_seq;
    logic        i_ack_ok;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_action;
    logic [31:0] o_frame_seq;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gbn_window_scoreboard sb;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    go_back_n_sender_window_unit #(
        .WINDOW_FRAMES(WINDOW_FRAMES),
        .QUEUE_FRAMES (QUEUE_FRAMES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_msg_len  (i_msg_len),
        .i_ack_seq  (i_ack_seq),
        .i_ack_ok   (i_ack_ok),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_action   (o_action),
        .o_frame_seq(o_frame_seq),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one event and hold it until transferred
    task automatic send_event(input logic [1:0] func, input logic [15:0] len,
                              input logic [31:0] ack, input logic ok);
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_msg_len  <= len;
        i_ack_seq  <= ack;
        i_ack_ok   <= ok;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_event(func, len, ack, ok);
    endtask

    // Pick an event from the current window state, mostly well-formed
    task automatic send_random_event();
        int unsigned pick;
        int unsigned fp;
        int unsigned lp;
        logic [1:0]  func;
        logic [15:0] len;
        logic [31:0] ack;
        logic        ok;

        func = FUNC_MSG;
        len  = 16'($urandom);
        ack  = $urandom;
        ok   = 1'($urandom);
        fp   = (sb.first_bytes == 0) ? 1 : sb.first_bytes;
        lp   = (sb.frame_bytes == 0) ? 1 : sb.frame_bytes;
        pick = $urandom_range(99);
        // Favor sliding acks while the queue is deep
        if (sb.queued() > 96 && pick < 60) begin
            pick = 40;
        end
        if (pick < 30) begin
            len = 16'($urandom_range(0, fp + 3 * lp));
        end else if (pick < 34) begin
            // full-range length, often rejected
        end else if (pick < 70) begin
            func = FUNC_ACK;
            ok   = 1'b1;
            if (sb.in_flight == 0) begin
                ack = sb.base_seq;
            end else if ($urandom_range(1) == 1) begin
                ack = sb.base_seq + sb.in_flight - 1;
            end else begin
                ack = sb.base_seq + $urandom_range(0, sb.in_flight - 1);
            end
        end else if (pick < 80) begin
            func = FUNC_TMO;
        end else if (pick < 88) begin
            func = FUNC_ACK;
            ok   = 1'b0;
            if ($urandom_range(1) == 1) begin
                ack = sb.base_seq;
            end
        end else if (pick < 94) begin
            func = FUNC_ACK;
            ok   = 1'b1;
        end else if (pick < 97) begin
            func = FUNC_ACK;
            ok   = 1'b1;
            ack  = sb.base_seq + sb.in_flight;
        end else begin
            func = FUNC_SPARE;
        end
        send_event(func, len, ack, ok);
    endtask

    task automatic sender_gap();
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    // Stop offering, wait for every pending action, then let the block settle
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one payload register, then read it back
    task automatic apb_write(input logic sel, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(sel, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== value) begin
            sb.fails++;
            $display("%0t: register readback mismatch: expected %0d, actual %0d",
                     $time, value, prdata[7:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: check transfers, drive ready with stalls and the long hold
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_action, o_frame_seq, o_last);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(3) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Cycle limit
    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int          ph;
        int unsigned done_events;
        logic [7:0]  first_v;
        logic [7:0]  frame_v;

        sb         = new();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_func     <= FUNC_MSG;
        i_msg_len  <= '0;
        i_ack_seq  <= '0;
        i_ack_ok   <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at the reset payload sizes
        send_event(FUNC_TMO,   16'd0,     32'd0,          1'b1); // timeout, empty window
        send_event(FUNC_ACK,   16'd0,     32'd0,          1'b1); // ack, empty queue
        send_event(FUNC_SPARE, 16'hFFFF,  32'hFFFF_FFFF,  1'b1); // unused code
        send_event(FUNC_MSG,   16'd0,     32'd0,          1'b0); // empty message
        send_event(FUNC_MSG,   16'hFFFF,  32'd0,          1'b0); // queued, timer running
        send_event(FUNC_ACK,   16'd0,     32'd0,          1'b0); // bad checksum
        send_event(FUNC_ACK,   16'd0,     32'hFFFF_FFFF,  1'b1); // far outside window
        send_event(FUNC_ACK,   16'd0,     32'd1,          1'b1); // just past window
        send_event(FUNC_ACK,   16'd0,     32'd0,          1'b1); // slide and refill
        send_event(FUNC_TMO,   16'd0,     32'd0,          1'b1); // resend window
        send_event(FUNC_MSG,   16'hFFFF,  32'd0,          1'b1); // fills the queue to its limit
        send_event(FUNC_ACK,   16'd0,     32'd8,          1'b1); // ack top of window
        send_event(FUNC_MSG,   16'd127,   32'd0,          1'b0); // exactly one frame
        send_event(FUNC_MSG,   16'd128,   32'd0,          1'b0); // one byte over
        send_event(FUNC_ACK,   16'd0,     32'd16,         1'b1);
        send_event(FUNC_TMO,   16'd0,     32'd0,          1'b0);

        // Random phases, one payload setting each
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_and_settle();
            case (ph)
                0: begin
                    first_v = 8'd1;
                    frame_v = 8'd1;
                end
                1: begin
                    first_v = 8'd255;
                    frame_v = 8'd255;
                end
                2: begin
                    first_v = 8'd0;
                    frame_v = 8'd0;
                end
                3: begin
                    first_v = 8'd255;
                    frame_v = 8'd1;
                end
                4: begin
                    first_v = 8'd1;
                    frame_v = 8'd255;
                end
                default: begin
                    first_v = 8'($urandom);
                    frame_v = 8'($urandom);
                end
            endcase
            apb_write(REG_FIRST, first_v);
            apb_write(REG_FRAME, frame_v);
            tx_idle_on = (ph != 2) && (ph != PHASE_COUNT - 1);
            rx_idle_on = tx_idle_on;
            // Long result hold while events keep coming
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            done_events = 0;
            while (done_events < PHASE_EVENTS) begin
                if (tx_idle_on && $urandom_range(2) == 0) begin
                    sender_gap();
                end
                send_random_event();
                done_events++;
            end
        end

        drain_and_settle();
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
